// ----- rtl/core/ccfg_pkg.sv -----
// ----------------------------------------------------------------------------
// ccfg_pkg - coulomb counter fuel gauge package
// Widths, constants, register indexes and divider interface types.
// ----------------------------------------------------------------------------
package ccfg_pkg;

  localparam int SMP_W     = 10;
  localparam int CUR_W     = 21;
  localparam int CAP_W     = 24;
  localparam int FRAC_W    = 26;
  localparam int HRS_W     = 16;
  localparam int MIN_W     = 6;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DIV_W     = 31;
  localparam int DVR_W     = 20;
  localparam int MUL_A_W   = 23;
  localparam int MUL_B_W   = 10;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  localparam int MIN_PER_HOUR = 60;

  localparam logic signed [FRAC_W-1:0] NAH_PER_MAH = 26'sd1000000;
  localparam logic signed [CAP_W-1:0]  CAP_RESET   = 24'sd6000;
  localparam logic signed [CAP_W-1:0]  CAP_MAX     = 24'sh7FFFFF;
  localparam logic signed [CAP_W-1:0]  CAP_MIN     = 24'sh800000;
  localparam logic [HRS_W-1:0]         HOURS_SAT   = 16'hFFFF;

  localparam logic [SMP_W-1:0] OFFSET_RESET    = 10'd18;
  localparam logic [SMP_W-1:0] GAIN_RESET      = 10'd131;
  localparam logic [SMP_W-1:0] TICK_RESET      = 10'd136;
  localparam logic [HRS_W-1:0] MAX_HOURS_RESET = 16'd999;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_OFFSET  = 2'd0,
    REG_MA_PER_STEP = 2'd1,
    REG_TICK_UMIN   = 2'd2,
    REG_MAX_HOURS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVR_W-1:0] rem;
  } div_res_t;

endpackage

// ----- rtl/core/ccfg_div.sv -----
// ----------------------------------------------------------------------------
// ccfg_div - shared unsigned divider
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module ccfg_div
  import ccfg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DVR_W-1:0] r_r, r_nxt;
  logic [DVR_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DVR_W:0]   trial;
  logic [DVR_W:0]   sub;
  logic             fits;

  assign trial = {r_r, q_r[DIV_W-1]};
  assign sub   = trial - {1'b0, d_r};
  assign fits  = trial >= {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIV_W-2:0], fits};
      r_nxt   = fits ? sub[DVR_W-1:0] : trial[DVR_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign res.done = done_r;
  assign res.quot = q_r;
  assign res.rem  = r_r;

endmodule

// ----- rtl/core/coulomb_counter_fuel_gauge.sv -----
// ----------------------------------------------------------------------------
// coulomb_counter_fuel_gauge - battery fuel gauge by charge counting
// Each sample passes through the current and charge multiplies, a charge division
// and an mAh carry loop that carries one mAh per step; when remaining time is
// computed, two more divisions follow on the shared divider.
// Throughput: one item at a time; the next item is accepted the cycle after
// the result enters the output register. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module coulomb_counter_fuel_gauge
  import ccfg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SMP_W-1:0]         in_adc_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CUR_W-1:0]  out_current_ma,
  output logic signed [CAP_W-1:0]  out_capacity_mah,
  output logic [HRS_W-1:0]         out_hours_left,
  output logic [MIN_W-1:0]         out_minutes_left,
  output logic                     out_time_valid,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL_I = 12'b0000_0000_0010,
    S_MUL_C = 12'b0000_0000_0100,
    S_CHG   = 12'b0000_0000_1000,
    S_CHGW  = 12'b0000_0001_0000,
    S_CARRY = 12'b0000_0010_0000,
    S_SAT   = 12'b0000_0100_0000,
    S_TDIV  = 12'b0000_1000_0000,
    S_TDIVW = 12'b0001_0000_0000,
    S_HDIV  = 12'b0010_0000_0000,
    S_HDIVW = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  localparam logic signed [CAP_W:0] CAPW_MAX = {CAP_MAX[CAP_W-1], CAP_MAX};
  localparam logic signed [CAP_W:0] CAPW_MIN = {CAP_MIN[CAP_W-1], CAP_MIN};

  state_t state_r, state_nxt;

  // configuration
  logic [SMP_W-1:0] offset_r, offset_nxt;
  logic [SMP_W-1:0] gain_r, gain_nxt;
  logic [SMP_W-1:0] tick_r, tick_nxt;
  logic [HRS_W-1:0] max_hours_r, max_hours_nxt;

  // gauge state
  logic signed [FRAC_W-1:0] frac_r, frac_nxt;
  logic signed [CAP_W-1:0]  cap_r, cap_nxt;

  // working registers
  logic [SMP_W-1:0]         samp_r, samp_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [CUR_W-1:0]  cur_r, cur_nxt;
  logic signed [FRAC_W-1:0] acc_r, acc_nxt;
  logic signed [CAP_W:0]    capw_r, capw_nxt;
  logic [DIV_W-1:0]         tot_r, tot_nxt;
  logic [HRS_W-1:0]         hrs_r, hrs_nxt;
  logic [MIN_W-1:0]         min_r, min_nxt;
  logic                     tv_r, tv_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CUR_W-1:0]  out_cur_r, out_cur_nxt;
  logic signed [CAP_W-1:0]  out_cap_r, out_cap_nxt;
  logic [HRS_W-1:0]         out_hrs_r, out_hrs_nxt;
  logic [MIN_W-1:0]         out_min_r, out_min_nxt;
  logic                     out_tv_r, out_tv_nxt;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p_r;

  div_req_t div_req;
  div_res_t div_res;

  logic signed [SMP_W:0]    diff;
  logic [SMP_W:0]           diff_abs;
  logic [CUR_W-1:0]         cur_mag;
  logic [CUR_W-1:0]         cur_abs;
  logic signed [FRAC_W-1:0] charge;
  logic                     cur_neg;
  logic                     cur_pos;
  logic signed [CAP_W-1:0]  cap_clamp;
  logic signed [CAP_W-1:0]  cap_fix;
  logic [DIV_W-1:0]         hq;

  assign diff     = $signed({1'b0, samp_r}) - $signed({1'b0, offset_r});
  assign diff_abs = diff[SMP_W] ? (-diff) : diff;
  assign cur_mag  = {1'b0, mul_p_r[CUR_W-2:0]};
  assign cur_abs  = -cur_r;
  assign cur_neg  = cur_r[CUR_W-1];
  assign cur_pos  = !cur_r[CUR_W-1] && (cur_r != '0);
  assign charge   = $signed({1'b0, div_res.quot[FRAC_W-2:0]});
  assign hq       = div_res.quot;

  always_comb begin
    if (capw_r > CAPW_MAX) begin
      cap_clamp = CAP_MAX;
    end else if (capw_r < CAPW_MIN) begin
      cap_clamp = CAP_MIN;
    end else begin
      cap_clamp = capw_r[CAP_W-1:0];
    end
    cap_fix = (cap_clamp[CAP_W-1] && cur_pos) ? '0 : cap_clamp;
  end

  always_comb begin
    state_nxt     = state_r;
    offset_nxt    = offset_r;
    gain_nxt      = gain_r;
    tick_nxt      = tick_r;
    max_hours_nxt = max_hours_r;
    frac_nxt      = frac_r;
    cap_nxt       = cap_r;
    samp_nxt      = samp_r;
    neg_nxt       = neg_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    capw_nxt      = capw_r;
    tot_nxt       = tot_r;
    hrs_nxt       = hrs_r;
    min_nxt       = min_r;
    tv_nxt        = tv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cur_nxt   = out_cur_r;
    out_cap_nxt   = out_cap_r;
    out_hrs_nxt   = out_hrs_r;
    out_min_nxt   = out_min_r;
    out_tv_nxt    = out_tv_r;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ADC_OFFSET:  offset_nxt    = cfg_wdata[SMP_W-1:0];
        REG_MA_PER_STEP: gain_nxt      = cfg_wdata[SMP_W-1:0];
        REG_TICK_UMIN:   tick_nxt      = cfg_wdata[SMP_W-1:0];
        REG_MAX_HOURS:   max_hours_nxt = cfg_wdata[HRS_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          samp_nxt  = in_adc_sample;
          state_nxt = S_MUL_I;
        end
      end
      S_MUL_I: begin
        mul_a     = MUL_A_W'(diff_abs);
        mul_b     = gain_r;
        neg_nxt   = diff[SMP_W];
        state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        cur_nxt   = neg_r ? $signed(-cur_mag) : $signed(cur_mag);
        mul_a     = MUL_A_W'(cur_mag);
        mul_b     = tick_r;
        state_nxt = S_CHG;
      end
      S_CHG: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p_r[DIV_W-1:0];
        div_req.divisor  = DVR_W'(MIN_PER_HOUR);
        state_nxt        = S_CHGW;
      end
      S_CHGW: begin
        if (div_res.done) begin
          acc_nxt   = cur_neg ? (frac_r - charge) : (frac_r + charge);
          capw_nxt  = {cap_r[CAP_W-1], cap_r};
          state_nxt = S_CARRY;
        end
      end
      S_CARRY: begin
        if (acc_r > NAH_PER_MAH) begin
          acc_nxt  = acc_r - NAH_PER_MAH;
          capw_nxt = capw_r + (CAP_W+1)'(1);
        end else if (acc_r < -NAH_PER_MAH) begin
          acc_nxt  = acc_r + NAH_PER_MAH;
          capw_nxt = capw_r - (CAP_W+1)'(1);
        end else begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        cap_nxt  = cap_fix;
        frac_nxt = acc_r;
        mul_a    = cap_fix[MUL_A_W-1:0];
        mul_b    = MUL_B_W'(MIN_PER_HOUR);
        if (cur_neg && !cap_fix[CAP_W-1]) begin
          state_nxt = S_TDIV;
        end else begin
          hrs_nxt   = '0;
          min_nxt   = '0;
          tv_nxt    = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_TDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p_r[DIV_W-1:0];
        div_req.divisor  = cur_abs[DVR_W-1:0];
        state_nxt        = S_TDIVW;
      end
      S_TDIVW: begin
        if (div_res.done) begin
          tot_nxt   = div_res.quot;
          state_nxt = S_HDIV;
        end
      end
      S_HDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = tot_r;
        div_req.divisor  = DVR_W'(MIN_PER_HOUR);
        state_nxt        = S_HDIVW;
      end
      S_HDIVW: begin
        if (div_res.done) begin
          hrs_nxt   = (|hq[DIV_W-1:HRS_W]) ? HOURS_SAT : hq[HRS_W-1:0];
          min_nxt   = div_res.rem[MIN_W-1:0];
          tv_nxt    = hq <= DIV_W'(max_hours_r);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cur_nxt   = cur_r;
          out_cap_nxt   = cap_r;
          out_hrs_nxt   = hrs_r;
          out_min_nxt   = min_r;
          out_tv_nxt    = tv_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      offset_r    <= OFFSET_RESET;
      gain_r      <= GAIN_RESET;
      tick_r      <= TICK_RESET;
      max_hours_r <= MAX_HOURS_RESET;
      frac_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      offset_r    <= offset_nxt;
      gain_r      <= gain_nxt;
      tick_r      <= tick_nxt;
      max_hours_r <= max_hours_nxt;
      frac_r      <= frac_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r    <= samp_nxt;
    neg_r     <= neg_nxt;
    cur_r     <= cur_nxt;
    acc_r     <= acc_nxt;
    capw_r    <= capw_nxt;
    tot_r     <= tot_nxt;
    hrs_r     <= hrs_nxt;
    min_r     <= min_nxt;
    tv_r      <= tv_nxt;
    out_cur_r <= out_cur_nxt;
    out_cap_r <= out_cap_nxt;
    out_hrs_r <= out_hrs_nxt;
    out_min_r <= out_min_nxt;
    out_tv_r  <= out_tv_nxt;
    mul_p_r   <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  ccfg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_current_ma   = out_cur_r;
  assign out_capacity_mah = out_cap_r;
  assign out_hours_left   = out_hrs_r;
  assign out_minutes_left = out_min_r;
  assign out_time_valid   = out_tv_r;

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (frac_r <= NAH_PER_MAH) && (frac_r >= -NAH_PER_MAH))
    else $error("charge fraction out of range");

  a_time_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_time_valid) |->
      (out_current_ma[CUR_W-1] && !out_capacity_mah[CAP_W-1]))
    else $error("time valid without discharge or with negative capacity");

  a_minutes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minutes_left < MIN_W'(MIN_PER_HOUR)))
    else $error("minutes out of range");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |->
      ((state_r == S_CHGW) || (state_r == S_TDIVW) || (state_r == S_HDIVW)))
    else $error("divider result outside a wait state");

endmodule
